// File: hdl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// LZW decoder package
// Shared constants and the status codes of the result items.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam logic [1:0] StatusData  = 2'd0;
  localparam logic [1:0] StatusEnd   = 2'd1;
  localparam logic [1:0] StatusLong  = 2'd2;

  localparam int unsigned CodeClear     = 256;
  localparam int unsigned CodeEnd       = 257;
  localparam int unsigned CodeFirstFree = 258;

endpackage

// File: hdl/lzwd_in_if.sv
// ----------------------------------------------------------------------------
// LZW decoder input channel
// Valid/ready channel that carries one compressed byte.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: hdl/lzwd_out_if.sv
// ----------------------------------------------------------------------------
// LZW decoder output channel
// Valid/ready channel that carries up to eight decoded bytes.
// ----------------------------------------------------------------------------
interface lzwd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last;
  logic [1:0]  status;

  modport source (output valid, output out_bytes, output byte_count, output last,
                  output status, input ready);
  modport sink (input valid, input out_bytes, input byte_count, input last,
                input status, output ready);
endinterface

// File: hdl/lzw_decoder_9_to_12_bit.sv
// ----------------------------------------------------------------------------
// LZW decoder, 9 to 12 bit codes
// Unpacks variable width codes and expands them through a dictionary.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one compressed byte per item; out_if carries result items of
//   up to eight bytes, first byte in the top bits, with last on the final one
//   for that input byte. A byte that completes no code gives no result.
// Flow:
//   A byte that completes no code is taken while idle. A data code then walks
//   its prefix chain through the dictionary memory, one entry per registered
//   read, and gathers the string byte by byte from the expansion stack, each
//   stack read registered, eight bytes per result item, each item held until
//   the receiver is ready. in_ready is low from the accepted byte until the
//   block is idle again.
// Reset:
//   Clears the bit gatherer, width, free code and flags. The dictionary needs
//   no clearing pass: only written entries are read.
// Stall:
//   While out_ready is low the current result holds and the block waits.
//   After the end code, bytes are still taken and dropped until reset.
// ----------------------------------------------------------------------------
module lzw_decoder_9_to_12_bit #(
  parameter int unsigned MAX_CODE_BITS  = 12,
  parameter int unsigned MAX_STRING_LEN = 512
) (
  input logic         clk_i,
  input logic         rst_ni,
  lzwd_in_if.sink     in_if,
  lzwd_out_if.source  out_if
);
  localparam int unsigned CB = MAX_CODE_BITS;
  localparam int unsigned TS = 1 << CB;
  localparam int unsigned SW = $clog2(MAX_STRING_LEN + 1);
  localparam int unsigned SA = $clog2(MAX_STRING_LEN);

  typedef enum logic [2:0] {
    StIdle, StDecode, StRead, StWalk, StEmit, StFlag
  } state_e;

  state_e state_q;

  // dictionary and expansion stack
  logic [CB-1:0] pfx_mem [TS];
  logic [7:0]    sfx_mem [TS];
  logic [7:0]    fst_mem [TS];
  logic [7:0]    stk_mem [MAX_STRING_LEN];

  logic [4:0]    width_q;
  logic [CB:0]   free_q;
  logic [CB-1:0] prev_q, code_q, cur_q;
  logic          have_prev_q, finished_q, unknown_q, rd_prev_q;
  logic [CB-1:0] rd_pfx_q;
  logic [7:0]    rd_sfx_q, rd_fst_q, first_src_q, first_prev_q, extra_q, stk_rd_q;
  logic [SW-1:0] n_q, emit_q, total_q, room_q;
  logic [63:0]   ob_q;
  logic [3:0]    cnt_q;
  logic          last_q, ovalid_q;
  logic [1:0]    status_q;

  logic          code_valid;
  logic [CB-1:0] code;
  logic          load;

  assign load = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == StIdle);

  lzwd_unpack #(.MaxCodeBits(CB)) u_unpack (
    .clk_i, .rst_ni, .load_i(load), .byte_i(in_if.data_byte), .width_i(width_q),
    .code_valid_o(code_valid), .code_o(code)
  );

  assign out_if.valid      = ovalid_q;
  assign out_if.out_bytes  = ob_q;
  assign out_if.byte_count = cnt_q;
  assign out_if.last       = last_q;
  assign out_if.status     = status_q;

  function automatic logic [4:0] width_for(input logic [CB:0] fc);
    logic [4:0] w;
    w = 5'd9;
    for (int i = 9; i < CB; i++) begin
      if (fc >= ((CB+1)'(1) << i)) w = 5'(i + 1);
    end
    return w;
  endfunction

  // dictionary read port
  always_ff @(posedge clk_i) begin
    rd_pfx_q <= pfx_mem[cur_q];
    rd_sfx_q <= sfx_mem[cur_q];
    rd_fst_q <= fst_mem[cur_q];
    stk_rd_q <= stk_mem[SA'(n_q - emit_q - SW'(1))];
  end

  logic          wr_en;
  logic [CB-1:0] wr_addr;
  logic [7:0]    first_src_now;
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pfx_mem[wr_addr] <= prev_q;
      sfx_mem[wr_addr] <= first_src_now;
      fst_mem[wr_addr] <= first_prev_q;
    end
  end
  assign wr_addr = CB'(free_q);

  logic          stk_we;
  logic [7:0]    stk_wd;
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[SA'(n_q)] <= stk_wd;
  end

  logic walk_lit;
  assign walk_lit = (cur_q < CB'(256));
  // the first step of the walk sees the source code itself
  assign first_src_now = (n_q == '0) ? (walk_lit ? cur_q[7:0] : rd_fst_q) : first_src_q;
  assign stk_we = (state_q == StWalk) && !rd_prev_q && (n_q < room_q);
  assign stk_wd = walk_lit ? cur_q[7:0] : rd_sfx_q;
  assign wr_en  = (state_q == StWalk) && !rd_prev_q && (walk_lit || n_q >= room_q)
                  && (free_q < (CB+1)'(TS));

  logic [2:0]    slot;
  assign slot = emit_q[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      width_q     <= 5'd9;
      free_q      <= (CB+1)'(lzwd_pkg::CodeFirstFree);
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      finished_q  <= 1'b0;
      ovalid_q    <= 1'b0;
      unknown_q   <= 1'b0;
      rd_prev_q   <= 1'b0;
      n_q         <= '0;
      emit_q      <= '0;
      total_q     <= '0;
      room_q      <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      status_q    <= lzwd_pkg::StatusData;
      ob_q        <= '0;
      code_q      <= '0;
      cur_q       <= '0;
      first_src_q <= '0;
      first_prev_q <= '0;
      extra_q     <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          // drop every code once the end code has been seen
          if (code_valid && !finished_q) begin
            code_q  <= code;
            state_q <= StDecode;
          end
        end
        StDecode: begin
          if (code_q == CB'(lzwd_pkg::CodeEnd)) begin
            finished_q <= 1'b1;
            status_q   <= lzwd_pkg::StatusEnd;
            state_q    <= StFlag;
          end else if (code_q == CB'(lzwd_pkg::CodeClear)) begin
            free_q      <= (CB+1)'(lzwd_pkg::CodeFirstFree);
            width_q     <= 5'd9;
            have_prev_q <= 1'b0;
            state_q     <= StIdle;
          end else if (!have_prev_q) begin
            if (code_q < CB'(256)) begin
              prev_q      <= code_q;
              have_prev_q <= 1'b1;
              ob_q        <= {code_q[7:0], 56'd0};
              cnt_q       <= 4'd1;
              last_q      <= 1'b1;
              status_q    <= lzwd_pkg::StatusData;
              ovalid_q    <= 1'b1;
              state_q     <= StEmit;
              emit_q      <= '0;
              total_q     <= '0;
            end else begin
              state_q <= StIdle;
            end
          end else begin
            // read first byte of previous string first
            unknown_q <= ({1'b0, code_q} >= free_q);
            room_q    <= ({1'b0, code_q} >= free_q) ? SW'(MAX_STRING_LEN - 1)
                                                    : SW'(MAX_STRING_LEN);
            cur_q     <= prev_q;
            rd_prev_q <= 1'b1;
            n_q       <= '0;
            state_q   <= StRead;
          end
        end
        StRead: begin
          // wait for the registered dictionary read
          state_q <= StWalk;
        end
        StWalk: begin
          if (rd_prev_q) begin
            first_prev_q <= walk_lit ? cur_q[7:0] : rd_fst_q;
            rd_prev_q    <= 1'b0;
            cur_q        <= unknown_q ? prev_q : code_q;
            state_q      <= StRead;
          end else begin
            if (n_q == '0) first_src_q <= first_src_now;
            if (n_q >= room_q || walk_lit) begin
              if (free_q < (CB+1)'(TS)) begin
                free_q  <= free_q + 1'b1;
                width_q <= width_for(free_q + 1'b1);
              end
              prev_q <= unknown_q ? CB'(free_q) : code_q;
              if (n_q >= room_q) begin
                status_q <= lzwd_pkg::StatusLong;
                state_q  <= StFlag;
              end else begin
                n_q      <= n_q + 1'b1;
                total_q  <= n_q + 1'b1 + SW'(unknown_q);
                extra_q  <= (n_q == '0) ? cur_q[7:0] : first_src_q;
                emit_q   <= '0;
                ob_q     <= '0;
                cnt_q    <= '0;
                status_q <= lzwd_pkg::StatusData;
                state_q  <= StEmit;
                // fill after stack read settles
                last_q   <= 1'b0;
              end
            end else begin
              n_q   <= n_q + 1'b1;
              cur_q <= rd_pfx_q;
              state_q <= StRead;
            end
          end
        end
        StEmit: begin
          if (ovalid_q) begin
            if (out_if.ready) begin
              ovalid_q <= 1'b0;
              ob_q     <= '0;
              cnt_q    <= '0;
              if (last_q) state_q <= StIdle;
            end
          end else begin
            // stack read of byte emit_q is registered behind its address
            if (rd_prev_q) begin
              rd_prev_q <= 1'b0;
              ob_q[63 - 8*slot -: 8] <= (emit_q < n_q) ? stk_rd_q : extra_q;
              cnt_q  <= 4'(slot) + 4'd1;
              emit_q <= emit_q + 1'b1;
              if (emit_q + 1'b1 == total_q) begin
                last_q   <= 1'b1;
                ovalid_q <= 1'b1;
              end else if (slot == 3'd7) begin
                ovalid_q <= 1'b1;
              end
            end else begin
              rd_prev_q <= 1'b1;
            end
          end
        end
        StFlag: begin
          if (!ovalid_q) begin
            ob_q     <= '0;
            cnt_q    <= '0;
            last_q   <= 1'b1;
            ovalid_q <= 1'b1;
          end else if (out_if.ready) begin
            ovalid_q <= 1'b0;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// File: hdl/lzwd_unpack.sv
// ----------------------------------------------------------------------------
// LZW code unpacker
// Gathers bytes MSB first and cuts one code of the current width per step.
// ----------------------------------------------------------------------------
module lzwd_unpack #(
  parameter int unsigned MaxCodeBits = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [7:0]             byte_i,
  input  logic [4:0]             width_i,
  output logic                   code_valid_o,
  output logic [MaxCodeBits-1:0] code_o
);
  localparam int unsigned AccW = 24;

  logic [AccW-1:0] acc_q, acc_d, acc_sh;
  logic [4:0]      held_q, held_d, held_sh;
  logic [4:0]      rem;
  logic [AccW-1:0] shifted;

  always_comb begin
    acc_sh  = {acc_q[AccW-9:0], byte_i};
    held_sh = held_q + 5'd8;
    rem     = held_sh - width_i;
    shifted = acc_sh >> rem;
    code_valid_o = load_i && (held_sh >= width_i);
    code_o  = MaxCodeBits'(shifted & ((AccW'(1) << width_i) - AccW'(1)));
    acc_d   = acc_q;
    held_d  = held_q;
    if (load_i) begin
      if (held_sh >= width_i) begin
        acc_d  = acc_sh & ((AccW'(1) << rem) - AccW'(1));
        held_d = rem;
      end else begin
        acc_d  = acc_sh;
        held_d = held_sh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
    end else begin
      acc_q  <= acc_d;
      held_q <= held_d;
    end
  end
endmodule

// File: hdl/lzwd_checker.sv
// ----------------------------------------------------------------------------
// LZW decoder port checker
// Checks result items seen on the ports of the decoder.
// ----------------------------------------------------------------------------
module lzwd_port_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  byte_count_i,
  input logic        last_i,
  input logic [1:0]  status_i,
  input logic [63:0] out_bytes_i
);
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> byte_count_i <= 4'd8) else $error("byte count above eight");
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != lzwd_pkg::StatusData |-> last_i && byte_count_i == 4'd0
    && out_bytes_i == 64'd0) else $error("flag item malformed");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> byte_count_i == 4'd8) else $error("short non-final item");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bytes_i))
    else $error("stalled item changed");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken during output");
endmodule

bind lzw_decoder_9_to_12_bit lzwd_port_props u_chk (
  .clk_i, .rst_ni, .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .byte_count_i(out_if.byte_count), .last_i(out_if.last), .status_i(out_if.status),
  .out_bytes_i(out_if.out_bytes)
);
